@@ rtl/assert_macros.svh @@
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property checked on every rising clock edge outside reset
`define OVL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// expression that must never be true outside reset
`define OVL_NEVER(lbl, expr, msg) \
  `OVL_ASSERT(lbl, !(expr), msg)
`else
`define OVL_ASSERT(lbl, prop, msg)
`define OVL_NEVER(lbl, expr, msg)
`endif

`endif

@@ rtl/ovl_pkg.sv @@
// types, constants and helper functions of the ordered value list
package ovl_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // command codes
  typedef enum logic [1:0] {
    CMD_APPEND  = 2'd0,
    CMD_PREPEND = 2'd1,
    CMD_DELETE  = 2'd2,
    CMD_READ    = 2'd3
  } cmd_e;

  // status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // per-cycle operation broadcast to every cell
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_APPEND,
    OP_PREPEND,
    OP_DELETE,
    OP_ROTATE
  } cell_op_e;

  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef struct packed {
    cell_op_e op;
    data_t    value;
  } cell_ctl_t;

  // position flags for one cell, derived from the fill count
  typedef struct packed {
    logic used;
    logic append_slot;
    logic tail;
  } cell_pos_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] item_value;
    logic               item_valid;
    logic               last;
    logic [4:0]         entry_count;
  } res_t;

  // keep the low DATA_WIDTH bits of an input value
  function automatic data_t to_stored(logic signed [31:0] v);
    logic [63:0] w;
    w = {32'b0, v};
    return w[DATA_WIDTH-1:0];
  endfunction

  // sign-extend a stored word and keep 32 bits
  function automatic logic signed [31:0] to_out(data_t s);
    logic [63:0] w;
    w = 64'(signed'(s));
    return w[31:0];
  endfunction

endpackage

@@ rtl/ovl_cell.sv @@
// one list cell: holds a single entry and moves it to or from its neighbors
module ovl_cell
  import ovl_pkg::*;
(
  input  logic      clk_i,
  input  cell_ctl_t ctl_i,
  input  cell_pos_t pos_i,
  input  data_t     left_data_i,
  input  data_t     right_data_i,
  input  data_t     head_data_i,
  input  logic      found_i,
  output logic      found_o,
  output data_t     data_o
);

  data_t data_q, data_d;
  logic  match;

  // delete match chain: this cell or one nearer the head matched
  assign match   = pos_i.used && (data_q == ctl_i.value);
  assign found_o = found_i | match;

  // next entry value
  always_comb begin
    data_d = data_q;
    case (ctl_i.op)
      OP_APPEND: begin
        if (pos_i.append_slot) data_d = ctl_i.value;
      end
      OP_PREPEND: data_d = left_data_i;
      OP_DELETE: begin
        if (found_o) data_d = right_data_i;
      end
      OP_ROTATE:  data_d = pos_i.tail ? head_data_i : right_data_i;
      default:    data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ rtl/ordered_value_list.sv @@
// ordered value list top level: control, fill count and the row of cells
//
// channel   direction  handshake                      payload
// command   in         start high, busy low           cmd_i (command, value)
// result    out        res_valid_o, one cycle each    res_o (status .. entry_count)
//
// append, prepend and delete give their result on the next cycle
// and busy stays low, so a command can be taken every cycle while no read-out runs.
// read-out of n entries gives n results on consecutive cycles; the cells rotate
// the list by one place per cycle and busy is high until the last one is out.
// reset clears the fill count and control; entries are unknown until written.
// results cannot be held off by the receiver.
`include "assert_macros.svh"

module ordered_value_list
  import ovl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  cmd_t cmd_i,
  output logic res_valid_o,
  output res_t res_o
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] rd_q, rd_d;
  logic             res_valid_q, res_valid_d;
  res_t             res_q, res_d;

  cell_ctl_t ctl;
  data_t     data [CAPACITY];
  logic      found [CAPACITY+1];
  logic      accept, full, empty, rd_last;

  assign busy    = (state_q == S_READ);
  assign accept  = start && !busy;
  assign full    = (cnt_q == CNT_W'(CAPACITY));
  assign empty   = (cnt_q == '0);
  assign rd_last = ((CNT_W'(rd_q) + CNT_W'(1)) == cnt_q);
  assign found[0] = 1'b0;

  // operation for the cell row
  always_comb begin
    ctl.value = to_stored(cmd_i.value);
    ctl.op    = OP_HOLD;
    if (accept) begin
      case (cmd_i.command)
        CMD_APPEND:  ctl.op = full ? OP_HOLD : OP_APPEND;
        CMD_PREPEND: ctl.op = full ? OP_HOLD : OP_PREPEND;
        CMD_DELETE:  ctl.op = OP_DELETE;
        CMD_READ:    ctl.op = OP_HOLD;
        default:     ctl.op = OP_HOLD;
      endcase
    end else if (state_q == S_READ) begin
      ctl.op = OP_ROTATE;
    end
  end

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_pos_t pos;
    data_t     left_data, right_data;

    assign pos.used        = (CNT_W'(i) < cnt_q);
    assign pos.append_slot = (CNT_W'(i) == cnt_q);
    assign pos.tail        = (CNT_W'(i + 1) == cnt_q);

    if (i == 0) begin : g_head
      assign left_data = ctl.value;
    end else begin : g_mid
      assign left_data = data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign right_data = data[i];
    end else begin : g_inner
      assign right_data = data[i+1];
    end

    ovl_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .pos_i       (pos),
      .left_data_i (left_data),
      .right_data_i(right_data),
      .head_data_i (data[0]),
      .found_i     (found[i]),
      .found_o     (found[i+1]),
      .data_o      (data[i])
    );
  end

  // next state, fill count and result
  always_comb begin
    state_d          = state_q;
    cnt_d            = cnt_q;
    rd_d             = rd_q;
    res_valid_d      = 1'b0;
    res_d.status     = ST_OK;
    res_d.item_value = '0;
    res_d.item_valid = 1'b0;
    res_d.last       = 1'b1;
    if (accept) begin
      res_valid_d = 1'b1;
      case (cmd_i.command)
        CMD_APPEND, CMD_PREPEND: begin
          if (full) res_d.status = ST_FULL;
          else      cnt_d        = cnt_q + CNT_W'(1);
        end
        CMD_DELETE: begin
          if (empty)                  res_d.status = ST_EMPTY;
          else if (!found[CAPACITY])  res_d.status = ST_NOT_FOUND;
          else                        cnt_d        = cnt_q - CNT_W'(1);
        end
        CMD_READ: begin
          if (empty) begin
            res_d.status = ST_EMPTY;
          end else begin
            res_valid_d = 1'b0;
            rd_d        = '0;
            state_d     = S_READ;
          end
        end
        default: res_d.status = ST_OK;
      endcase
    end else if (state_q == S_READ) begin
      res_valid_d      = 1'b1;
      res_d.item_value = to_out(data[0]);
      res_d.item_valid = 1'b1;
      res_d.last       = rd_last;
      if (rd_last) state_d = S_IDLE;
      else         rd_d    = rd_q + IDX_W'(1);
    end
    res_d.entry_count = 5'(cnt_d);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rd_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_q        <= rd_d;
      res_valid_q <= res_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `OVL_NEVER(a_cnt_range, cnt_q > CNT_W'(CAPACITY), "fill count above capacity")
  `OVL_ASSERT(a_read_nonempty, (state_q == S_READ) |-> !empty, "read-out of an empty list")
  `OVL_ASSERT(a_read_cnt_stable, (state_q == S_READ) |=> $stable(cnt_q), "count moved in read-out")
  `OVL_ASSERT(a_read_emits, (state_q == S_READ) |=> res_valid_q, "read-out cycle gave no result")
  `OVL_ASSERT(a_last_ends_read, (state_q == S_READ && rd_last) |=> (state_q == S_IDLE),
              "read-out did not end on its last entry")

endmodule

@@ test/testbench.sv @@
// self-checking testbench for the ordered value list: directed and random command streams
module testbench
  import ovl_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_ITEMS  = 260;
  localparam int CALM_TAIL  = 40;
  localparam int MAX_CYCLES = 200000;

  // list predictor and store of expected results
  class list_scoreboard;
    data_t contents[$];
    res_t  expected[$];
    int    failures;

    function new();
      failures = 0;
    endfunction

    // work out the results of one accepted command transfer
    function void note_command(cmd_t c);
      res_t r;
      int   n;
      int   hit;
      n   = contents.size();
      hit = -1;
      r   = '0;
      r.last = 1'b1;
      case (cmd_e'(c.command))
        CMD_APPEND, CMD_PREPEND: begin
          if (n >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            if (cmd_e'(c.command) == CMD_APPEND) contents.push_back(c.value);
            else contents.push_front(c.value);
            r.status = ST_OK;
          end
        end
        CMD_DELETE: begin
          if (n == 0) begin
            r.status = ST_EMPTY;
          end else begin
            // first match counted from the head
            for (int k = 0; k < n; k++)
              if (hit < 0 && contents[k] == c.value) hit = k;
            if (hit < 0) begin
              r.status = ST_NOT_FOUND;
            end else begin
              contents.delete(hit);
              r.status = ST_OK;
            end
          end
        end
        default: begin
          if (n == 0) begin
            r.status = ST_EMPTY;
          end else begin
            // one result per entry, head first
            for (int k = 0; k < n; k++) begin
              r.status      = ST_OK;
              r.item_value  = contents[k];
              r.item_valid  = 1'b1;
              r.last        = (k == n - 1);
              r.entry_count = 5'(n);
              expected.push_back(r);
            end
            return;
          end
        end
      endcase
      r.entry_count = 5'(contents.size());
      expected.push_back(r);
    endfunction

    // compare one result transfer with the oldest expectation
    function void check_result(res_t got);
      res_t want;
      if (expected.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: result with nothing pending: status %0d value %0d valid %0b last %0b count %0d",
                   $realtime, got.status, got.item_value, got.item_valid, got.last,
                   got.entry_count);
        return;
      end
      want = expected.pop_front();
      if (got.status !== want.status || got.item_value !== want.item_value ||
          got.item_valid !== want.item_valid || got.last !== want.last ||
          got.entry_count !== want.entry_count) begin
        failures++;
        if (failures <= 10) begin
          $display("%0t: mismatch, expected status %0d value %0d valid %0b last %0b count %0d",
                   $realtime, want.status, want.item_value, want.item_valid, want.last,
                   want.entry_count);
          $display("%0t:           got status %0d value %0d valid %0b last %0b count %0d",
                   $realtime, got.status, got.item_value, got.item_valid, got.last,
                   got.entry_count);
        end
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  cmd_t cmd_i;
  logic res_valid_o;
  res_t res_o;

  list_scoreboard sb;

  ordered_value_list dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    repeat (MAX_CYCLES) @(posedge clk_i);
    $display("[ordered_value_list] ERROR");
    $finish;
  end

  // result monitor, sampled mid-cycle where outputs are settled
  always @(negedge clk_i) begin
    if (rst_ni === 1'b1 && res_valid_o === 1'b1) sb.check_result(res_o);
  end

  // one command transfer; called just after a rising edge, returns just after one
  task automatic send_command(input cmd_e op, input logic [31:0] v);
    cmd_t c;
    c.command = op;
    c.value   = v;
    start <= 1'b1;
    cmd_i <= c;
    @(negedge clk_i);
    while (busy !== 1'b0) @(negedge clk_i);
    sb.note_command(c);
    @(posedge clk_i);
  endtask

  // sender gap with junk on the command bus
  task automatic idle_cycles(input int n);
    repeat (n) begin
      start <= 1'b0;
      cmd_i <= {2'($urandom()), $urandom()};
      @(posedge clk_i);
    end
  endtask

  // hold off until every expected result has come
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // operand choice: an entry now in the list, a corner value, or anything
  function automatic logic [31:0] pick_value(input bit from_list);
    logic [31:0] corners[7];
    corners = '{32'h0, 32'h1, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h2, 32'h3};
    if (from_list && sb.contents.size() != 0)
      return sb.contents[$urandom_range(0, sb.contents.size() - 1)];
    if ($urandom_range(0, 2) == 0) return corners[$urandom_range(0, 6)];
    return $urandom();
  endfunction

  // stimulus
  initial begin
    bit   grow;
    bit   gaps_on;
    int   pick;
    cmd_e op;

    sb      = new();
    rst_ni  = 1'b0;
    start   = 1'b0;
    cmd_i   = '0;
    grow    = 1'b1;
    gaps_on = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list cases
    send_command(CMD_READ, $urandom());
    send_command(CMD_DELETE, 32'h0);
    // extremes at both ends, then read-out
    send_command(CMD_APPEND, 32'h7fff_ffff);
    send_command(CMD_PREPEND, 32'h8000_0000);
    send_command(CMD_APPEND, 32'h0);
    send_command(CMD_APPEND, 32'hffff_ffff);
    send_command(CMD_READ, $urandom());
    // absent value, tail and head removal
    send_command(CMD_DELETE, 32'h5);
    send_command(CMD_DELETE, 32'hffff_ffff);
    send_command(CMD_DELETE, 32'h8000_0000);
    // fill up, then inserts into a full list
    for (int k = 0; k < CAPACITY - 2; k++)
      send_command((k % 2) ? CMD_PREPEND : CMD_APPEND, (k < 3) ? 32'h0 : $urandom());
    send_command(CMD_APPEND, $urandom());
    send_command(CMD_PREPEND, $urandom());
    send_command(CMD_READ, $urandom());
    drain();

    // random part: growth and shrink phases
    for (int i = 0; i < RUN_ITEMS; i++) begin
      if (i % 30 == 0) grow = ~grow;
      if (i % 40 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      if (i == RUN_ITEMS / 2) drain();
      if (gaps_on && i < RUN_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0)
        idle_cycles($urandom_range(1, 8));
      pick = $urandom_range(0, 99);
      if (grow)
        op = (pick < 40) ? CMD_APPEND : (pick < 80) ? CMD_PREPEND :
             (pick < 90) ? CMD_DELETE : CMD_READ;
      else
        op = (pick < 15) ? CMD_APPEND : (pick < 30) ? CMD_PREPEND :
             (pick < 88) ? CMD_DELETE : CMD_READ;
      send_command(op, pick_value(op == CMD_DELETE && $urandom_range(0, 4) != 0));
    end

    // wait out the tail
    start <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (CAPACITY + 4) @(negedge clk_i);

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("[ordered_value_list] OK");
    end else begin
      $display("[ordered_value_list] ERROR");
    end
    $finish;
  end

endmodule
